### design/cfl_timestep_reduction_top_defines.svh
// ----------------------------------------------------------------------------
// CFL time-step reduction assertion macros
// Shared assertion helpers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef CFL_TIMESTEP_REDUCTION_TOP_DEFINES_SVH
`define CFL_TIMESTEP_REDUCTION_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CFL_ASSERT_IMP(label, a, b) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("assertion failed");
`define CFL_ASSERT_NXT(label, a, b) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define CFL_ASSERT_IMP(label, a, b)
`define CFL_ASSERT_NXT(label, a, b)
`endif
`endif

### design/cfl_pkg.sv
// ----------------------------------------------------------------------------
// CFL time-step reduction package
// Widths, register indexes, controller states and control/status bundles.
// ----------------------------------------------------------------------------
package cfl_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned GammaBits = 19;
  localparam int unsigned CourantBits = 17;
  localparam int unsigned ProdBits = GammaBits + WordBits;
  localparam int unsigned QBits = 2 * WordBits - FracBits;
  localparam int unsigned CntBits = 6;

  localparam logic [WordBits-1:0] WordMax = '1;
  localparam logic [GammaBits-1:0] GammaReset = GammaBits'(109227);
  localparam logic [CourantBits-1:0] CourantReset = CourantBits'(26214);
  localparam logic [1:0] DimsReset = 2'd3;
  localparam logic [WordBits-1:0] InitReset = WordBits'(65536);

  typedef enum logic [1:0] {
    REG_GAMMA   = 2'd0,
    REG_COURANT = 2'd1,
    REG_DIMS    = 2'd2,
    REG_INITIAL = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_QSTART,
    ST_QDIV,
    ST_RSTART,
    ST_ROOT,
    ST_TSTART,
    ST_TDIV,
    ST_TFOLD,
    ST_SCALE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic       mul_scale;
    logic       div_start;
    logic       div_time;
    logic       root_start;
    logic       fold;
    logic       emit;
    logic [1:0] dim;
  } cmd_t;

  typedef struct packed {
    logic       div_busy;
    logic       root_busy;
    logic       last;
    logic       out_free;
    logic [1:0] dims;
  } status_t;

endpackage

### design/cfl_datapath.sv
// ----------------------------------------------------------------------------
// CFL time-step reduction datapath
// Item and configuration registers, shared multiplier, iterative divider,
// iterative square root, running minimum and the output register.
// ----------------------------------------------------------------------------
module cfl_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cfl_pkg::cmd_t                   cmd_i,
  output cfl_pkg::status_t                status_o,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [cfl_pkg::WordBits-1:0]    cfg_data_i,
  input  logic [8*cfl_pkg::WordBits-1:0]  in_data_i,
  input  logic                            in_last_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [cfl_pkg::WordBits-1:0]    out_step_o,
  output logic [1:0]                      out_flags_o
);

  localparam int unsigned W = cfl_pkg::WordBits;
  localparam int unsigned P = cfl_pkg::ProdBits;

  logic [cfl_pkg::GammaBits-1:0]   gamma_q;
  logic [cfl_pkg::CourantBits-1:0] courant_q;
  logic [1:0]                      dims_q;
  logic [W-1:0] rho_q, p_q;
  logic [W-1:0] vel_q [3];
  logic [W-1:0] wid_q [3];
  logic         last_q;
  logic [P-1:0] prod_q;
  logic [W-1:0] min_q, prev_q, cs_q, spd_q;
  logic         degen_q;

  logic [P-1:0] dvd_q;
  logic [W-1:0] dsr_q, rem_q;
  logic [cfl_pkg::CntBits-1:0] dcnt_q;
  logic         dbusy_q;

  logic [2*W-1:0] rx_q;
  logic [W+2:0]   rrem_q;
  logic [cfl_pkg::CntBits-1:0] rcnt_q;
  logic         rbusy_q;

  logic         ovalid_q;
  logic [W-1:0] ostep_q;
  logic [1:0]   oflags_q;

  logic [W-1:0]   vel_sel, mag;
  logic [W:0]     spd_sum;
  logic [W-1:0]   spd_w;
  logic [W:0]     remsh;
  logic           dbit;
  logic [W-1:0]   quo_sat;
  logic [cfl_pkg::QBits-1:0] q_sat;
  logic [W+2:0]   rtrial, rsub;
  logic [cfl_pkg::GammaBits-1:0] mul_a;
  logic [W-1:0]   mul_b;
  logic [W-1:0]   scaled, twice;
  logic           capped;

  always_comb begin
    vel_sel = vel_q[cmd_i.dim];
    mag = vel_sel[W-1] ? (~vel_sel + W'(1)) : vel_sel;
    spd_sum = {1'b0, mag} + {1'b0, cs_q};
    spd_w = spd_sum[W] ? cfl_pkg::WordMax : spd_sum[W-1:0];
    remsh = {rem_q, dvd_q[P-1]};
    dbit = (remsh >= {1'b0, dsr_q});
    quo_sat = (dvd_q[P-1:W] != '0) ? cfl_pkg::WordMax : dvd_q[W-1:0];
    q_sat = (dvd_q[P-1:cfl_pkg::QBits] != '0) ? '1 : dvd_q[cfl_pkg::QBits-1:0];
    rtrial = {rrem_q[W:0], rx_q[2*W-1:2*W-2]};
    rsub = {1'b0, cs_q, 2'b01};
    mul_a = cmd_i.mul_scale ? cfl_pkg::GammaBits'(courant_q) : gamma_q;
    mul_b = cmd_i.mul_scale ? min_q : p_q;
    scaled = (prod_q[P-1:W+cfl_pkg::FracBits] != '0) ? cfl_pkg::WordMax :
             prod_q[W+cfl_pkg::FracBits-1:cfl_pkg::FracBits];
    twice = prev_q[W-1] ? cfl_pkg::WordMax : {prev_q[W-2:0], 1'b0};
    capped = (twice < scaled);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q   <= cfl_pkg::GammaReset;
      courant_q <= cfl_pkg::CourantReset;
      dims_q    <= cfl_pkg::DimsReset;
      prev_q    <= cfl_pkg::InitReset;
      min_q     <= cfl_pkg::WordMax;
      degen_q   <= 1'b0;
      dbusy_q   <= 1'b0;
      dcnt_q    <= '0;
      rbusy_q   <= 1'b0;
      rcnt_q    <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfl_pkg::reg_idx_e'(cfg_idx_i))
          cfl_pkg::REG_GAMMA:   gamma_q <= cfg_data_i[cfl_pkg::GammaBits-1:0];
          cfl_pkg::REG_COURANT: courant_q <= cfg_data_i[cfl_pkg::CourantBits-1:0];
          cfl_pkg::REG_DIMS:    dims_q <= cfg_data_i[1:0];
          cfl_pkg::REG_INITIAL: prev_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load && in_data_i[W-1:0] == '0) begin
        degen_q <= 1'b1;
      end
      if (cmd_i.div_start) begin
        dbusy_q <= 1'b1;
        dcnt_q <= cfl_pkg::CntBits'(P);
      end else if (dbusy_q) begin
        dcnt_q <= dcnt_q - 1'b1;
        if (dcnt_q == cfl_pkg::CntBits'(1)) begin
          dbusy_q <= 1'b0;
        end
      end
      if (cmd_i.root_start) begin
        rbusy_q <= 1'b1;
        rcnt_q <= cfl_pkg::CntBits'(W);
      end else if (rbusy_q) begin
        rcnt_q <= rcnt_q - 1'b1;
        if (rcnt_q == cfl_pkg::CntBits'(1)) begin
          rbusy_q <= 1'b0;
        end
      end
      if (cmd_i.fold) begin
        if (spd_q == '0) begin
          degen_q <= 1'b1;
        end
        if (quo_sat < min_q) begin
          min_q <= quo_sat;
        end
      end
      if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      if (cmd_i.emit) begin
        ovalid_q <= 1'b1;
        prev_q <= capped ? twice : scaled;
        min_q <= cfl_pkg::WordMax;
        degen_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rho_q <= in_data_i[W-1:0];
      p_q <= in_data_i[2*W-1:W];
      for (int i = 0; i < 3; i++) begin
        vel_q[i] <= in_data_i[(2+i)*W +: W];
        wid_q[i] <= in_data_i[(5+i)*W +: W];
      end
      last_q <= in_last_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= P'(mul_a) * P'(mul_b);
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      if (cmd_i.div_time) begin
        dvd_q <= P'({wid_q[cmd_i.dim], cfl_pkg::FracBits'(0)});
        dsr_q <= spd_w;
        spd_q <= spd_w;
      end else begin
        dvd_q <= prod_q;
        dsr_q <= rho_q;
      end
    end else if (dbusy_q) begin
      rem_q <= dbit ? W'(remsh - {1'b0, dsr_q}) : remsh[W-1:0];
      dvd_q <= {dvd_q[P-2:0], dbit};
    end
    if (cmd_i.root_start) begin
      rx_q <= {q_sat, cfl_pkg::FracBits'(0)};
      rrem_q <= '0;
      cs_q <= '0;
    end else if (rbusy_q) begin
      rx_q <= {rx_q[2*W-3:0], 2'b00};
      if (rtrial >= rsub) begin
        rrem_q <= rtrial - rsub;
        cs_q <= {cs_q[W-2:0], 1'b1};
      end else begin
        rrem_q <= rtrial;
        cs_q <= {cs_q[W-2:0], 1'b0};
      end
    end
    if (cmd_i.emit) begin
      ostep_q <= capped ? twice : scaled;
      oflags_q <= {degen_q, capped};
    end
  end

  assign status_o.div_busy = dbusy_q;
  assign status_o.root_busy = rbusy_q;
  assign status_o.last = last_q;
  assign status_o.out_free = !ovalid_q || out_ready_i;
  assign status_o.dims = (dims_q == 2'd0) ? 2'd1 : dims_q;
  assign out_valid_o = ovalid_q;
  assign out_step_o = ostep_q;
  assign out_flags_o = oflags_q;

endmodule

### design/cfl_ctrl.sv
// ----------------------------------------------------------------------------
// CFL time-step reduction controller
// Sequences the multiplier, divider and square root for one cell at a time.
// ----------------------------------------------------------------------------
module cfl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cfl_pkg::status_t status_i,
  output cfl_pkg::cmd_t    cmd_o
);

  cfl_pkg::state_e state_q, state_d;
  logic [1:0] dim_q, dim_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfl_pkg::ST_IDLE;
      dim_q <= '0;
    end else begin
      state_q <= state_d;
      dim_q <= dim_d;
    end
  end

  always_comb begin
    state_d = state_q;
    dim_d = dim_q;
    cmd_o = '0;
    cmd_o.dim = dim_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      cfl_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = cfl_pkg::ST_MUL;
        end
      end
      cfl_pkg::ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d = cfl_pkg::ST_QSTART;
      end
      cfl_pkg::ST_QSTART: begin
        cmd_o.div_start = 1'b1;
        state_d = cfl_pkg::ST_QDIV;
      end
      cfl_pkg::ST_QDIV: begin
        if (!status_i.div_busy) begin
          state_d = cfl_pkg::ST_RSTART;
        end
      end
      cfl_pkg::ST_RSTART: begin
        cmd_o.root_start = 1'b1;
        state_d = cfl_pkg::ST_ROOT;
      end
      cfl_pkg::ST_ROOT: begin
        if (!status_i.root_busy) begin
          dim_d = '0;
          state_d = cfl_pkg::ST_TSTART;
        end
      end
      cfl_pkg::ST_TSTART: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_time = 1'b1;
        state_d = cfl_pkg::ST_TDIV;
      end
      cfl_pkg::ST_TDIV: begin
        if (!status_i.div_busy) begin
          state_d = cfl_pkg::ST_TFOLD;
        end
      end
      cfl_pkg::ST_TFOLD: begin
        cmd_o.fold = 1'b1;
        if (dim_q + 2'd1 == status_i.dims) begin
          state_d = status_i.last ? cfl_pkg::ST_SCALE : cfl_pkg::ST_IDLE;
        end else begin
          dim_d = dim_q + 2'd1;
          state_d = cfl_pkg::ST_TSTART;
        end
      end
      cfl_pkg::ST_SCALE: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_scale = 1'b1;
        state_d = cfl_pkg::ST_EMIT;
      end
      cfl_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = cfl_pkg::ST_IDLE;
        end
      end
      default: state_d = cfl_pkg::ST_IDLE;
    endcase
  end

endmodule

### design/cfl_timestep_reduction_top.sv
// ----------------------------------------------------------------------------
// CFL time-step reduction top level
// One grid cell per transaction; a time step is emitted after the last cell.
// ----------------------------------------------------------------------------
// Each cell's processing time is set by the shared one-bit-per-cycle divider,
// which runs 51 steps for gamma * p / rho and once per dimension for the
// crossing time, plus a 32-step square root; a last cell adds the scale and
// emit states, and stalls in the emit state while an earlier result still
// waits in the output register. Cells are taken one at a time, and a finished
// result waits in the output register while the next cell is processed.
`include "cfl_timestep_reduction_top_defines.svh"
module cfl_timestep_reduction_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [cfl_pkg::WordBits-1:0]   cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // density, pressure, velocity_x, velocity_y, velocity_z, width_x, width_y, width_z
  input  logic [8*cfl_pkg::WordBits-1:0] s_axis_tdata,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // new_step
  output logic [cfl_pkg::WordBits-1:0]   m_axis_tdata,
  // growth_capped, degenerate_cell
  output logic [1:0]                     m_axis_tuser
);

  cfl_pkg::cmd_t    cmd;
  cfl_pkg::status_t status;

  cfl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cfl_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_step_o  (m_axis_tdata),
    .out_flags_o (m_axis_tuser)
  );

  `CFL_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `CFL_ASSERT_IMP(a_valid_from_emit, $rose(m_axis_tvalid), $past(cmd.emit))
  `CFL_ASSERT_IMP(a_div_idle_on_start, cmd.div_start, !status.div_busy)

endmodule
